FILE: hdl/rvx_pkg.sv
// Shared types and constants for the RV32I integer execute block.
`timescale 1ns / 1ps

package rvx_pkg;

    localparam int unsigned XLEN = 32;

    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

    localparam logic [2:0] F3_ADD  = 3'b000;
    localparam logic [2:0] F3_SLL  = 3'b001;
    localparam logic [2:0] F3_SLT  = 3'b010;
    localparam logic [2:0] F3_SLTU = 3'b011;
    localparam logic [2:0] F3_XOR  = 3'b100;
    localparam logic [2:0] F3_SR   = 3'b101;
    localparam logic [2:0] F3_OR   = 3'b110;
    localparam logic [2:0] F3_AND  = 3'b111;

    localparam logic [2:0] F3_BEQ  = 3'b000;
    localparam logic [2:0] F3_BNE  = 3'b001;
    localparam logic [2:0] F3_BLT  = 3'b100;
    localparam logic [2:0] F3_BGE  = 3'b101;
    localparam logic [2:0] F3_BLTU = 3'b110;
    localparam logic [2:0] F3_BGEU = 3'b111;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_MISALIGN  = 2'd1,
        ST_ILLEGAL   = 2'd2,
        ST_ELSEWHERE = 2'd3
    } t_status;

    typedef struct packed {
        logic              illegal;
        logic [XLEN-1:0]   value;
    } t_alu_res;

    typedef struct packed {
        logic illegal;
        logic taken;
    } t_br_res;

    typedef struct packed {
        t_status           status;
        logic [XLEN-1:0]   next_pc;
        logic [XLEN-1:0]   dest_value;
        logic              dest_write;
        logic [4:0]        dest_index;
    } t_exec_res;

endpackage

FILE: hdl/rvx_alu.sv
// Integer ALU for the OP and OP-IMM groups.
`timescale 1ns / 1ps

module rvx_alu
    import rvx_pkg::*;
(
    input  logic [31:0]    i_instruction,
    input  logic [31:0]    i_rs1_value,
    input  logic [31:0]    i_rs2_value,
    output t_alu_res       o_res
);

    logic        w_is_reg;
    logic        w_alt;
    logic [31:0] w_imm;
    logic [31:0] w_b;
    logic [4:0]  w_sh;

    assign w_is_reg = i_instruction[5];
    assign w_alt    = i_instruction[30];
    assign w_imm    = {{20{i_instruction[31]}}, i_instruction[31:20]};
    assign w_b      = w_is_reg ? i_rs2_value : w_imm;
    assign w_sh     = w_b[4:0];

    always_comb begin
        o_res.illegal = w_is_reg && i_instruction[25];
        unique case (i_instruction[14:12])
            F3_ADD:  o_res.value = (w_is_reg && w_alt) ? (i_rs1_value - w_b)
                                                       : (i_rs1_value + w_b);
            F3_SLL:  o_res.value = i_rs1_value << w_sh;
            F3_SLT:  o_res.value = {31'd0, ($signed(i_rs1_value) < $signed(w_b))};
            F3_SLTU: o_res.value = {31'd0, (i_rs1_value < w_b)};
            F3_XOR:  o_res.value = i_rs1_value ^ w_b;
            F3_SR:   o_res.value = w_alt ? 32'($signed(i_rs1_value) >>> w_sh)
                                         : (i_rs1_value >> w_sh);
            F3_OR:   o_res.value = i_rs1_value | w_b;
            default: o_res.value = i_rs1_value & w_b;
        endcase
    end

endmodule

FILE: hdl/rvx_branch.sv
// Branch condition evaluation.
`timescale 1ns / 1ps

module rvx_branch
    import rvx_pkg::*;
(
    input  logic [2:0]     i_funct3,
    input  logic [31:0]    i_rs1_value,
    input  logic [31:0]    i_rs2_value,
    output t_br_res        o_res
);

    logic w_eq;
    logic w_lt;
    logic w_ltu;

    assign w_eq  = (i_rs1_value == i_rs2_value);
    assign w_lt  = ($signed(i_rs1_value) < $signed(i_rs2_value));
    assign w_ltu = (i_rs1_value < i_rs2_value);

    always_comb begin
        o_res.illegal = 1'b0;
        unique case (i_funct3)
            F3_BEQ:  o_res.taken = w_eq;
            F3_BNE:  o_res.taken = !w_eq;
            F3_BLT:  o_res.taken = w_lt;
            F3_BGE:  o_res.taken = !w_lt;
            F3_BLTU: o_res.taken = w_ltu;
            F3_BGEU: o_res.taken = !w_ltu;
            default: begin
                o_res.taken   = 1'b0;
                o_res.illegal = 1'b1;
            end
        endcase
    end

endmodule

FILE: hdl/rvx_exec.sv
// Instruction decode and result selection for one instruction.
`timescale 1ns / 1ps

module rvx_exec
    import rvx_pkg::*;
(
    input  logic [31:0]    i_instruction,
    input  logic [31:0]    i_pc,
    input  logic [31:0]    i_rs1_value,
    input  logic [31:0]    i_rs2_value,
    output t_exec_res      o_res
);

    t_alu_res    w_alu;
    t_br_res     w_br;
    logic [6:0]  w_opc;
    logic [4:0]  w_rd;
    logic [31:0] w_imm_i;
    logic [31:0] w_imm_u;
    logic [31:0] w_off_j;
    logic [31:0] w_off_b;
    logic [31:0] w_pc4;
    logic [31:0] w_jalr_sum;
    t_status     w_st;
    logic [4:0]  w_idx;
    logic [31:0] w_val;
    logic [31:0] w_npc;

    rvx_alu u_alu (
        .i_instruction (i_instruction),
        .i_rs1_value   (i_rs1_value),
        .i_rs2_value   (i_rs2_value),
        .o_res         (w_alu)
    );

    rvx_branch u_branch (
        .i_funct3    (i_instruction[14:12]),
        .i_rs1_value (i_rs1_value),
        .i_rs2_value (i_rs2_value),
        .o_res       (w_br)
    );

    assign w_opc   = i_instruction[6:0];
    assign w_rd    = i_instruction[11:7];
    assign w_imm_i = {{20{i_instruction[31]}}, i_instruction[31:20]};
    assign w_imm_u = {i_instruction[31:12], 12'd0};
    assign w_off_j = {{11{i_instruction[31]}}, i_instruction[31], i_instruction[19:12],
                      i_instruction[20], i_instruction[30:21], 1'b0};
    assign w_off_b = {{19{i_instruction[31]}}, i_instruction[31], i_instruction[7],
                      i_instruction[30:25], i_instruction[11:8], 1'b0};
    assign w_pc4      = i_pc + 32'd4;
    assign w_jalr_sum = i_rs1_value + w_imm_i;

    always_comb begin
        w_st  = ST_DONE;
        w_idx = w_rd;
        w_val = 32'd0;
        w_npc = w_pc4;
        if (i_pc[1:0] != 2'd0) begin
            w_st = ST_MISALIGN;
        end else begin
            unique case (w_opc)
                OPC_LUI:   w_val = w_imm_u;
                OPC_AUIPC: w_val = i_pc + w_imm_u;
                OPC_JAL: begin
                    w_val = w_pc4;
                    w_npc = i_pc + w_off_j;
                end
                OPC_JALR: begin
                    w_val = w_pc4;
                    w_npc = {w_jalr_sum[31:1], 1'b0};
                end
                OPC_BRANCH: begin
                    w_idx = 5'd0;
                    if (w_br.illegal) begin
                        w_st = ST_ILLEGAL;
                    end else if (w_br.taken) begin
                        w_npc = i_pc + w_off_b;
                    end
                end
                OPC_OPIMM, OPC_OP: begin
                    if (w_alu.illegal) begin
                        w_st = ST_ILLEGAL;
                    end else begin
                        w_val = w_alu.value;
                    end
                end
                OPC_LOAD, OPC_STORE, OPC_SYSTEM: w_st = ST_ELSEWHERE;
                default: w_st = ST_ILLEGAL;
            endcase
        end
    end

    always_comb begin
        if (w_st != ST_DONE) begin
            o_res.dest_index = 5'd0;
            o_res.dest_write = 1'b0;
            o_res.dest_value = 32'd0;
            o_res.next_pc    = i_pc;
        end else begin
            o_res.dest_index = w_idx;
            o_res.dest_write = (w_idx != 5'd0);
            o_res.dest_value = w_val;
            o_res.next_pc    = w_npc;
        end
        o_res.status = w_st;
    end

endmodule

FILE: hdl/rv32i_integer_execute.sv
// Top level: RV32I integer execute unit with input and result registers.
// An accepted item is held in the input register, then loaded into the result register once the output is free.
// Throughput: one item per cycle while the receiver accepts results; both stages advance together with no bubbles.
// The critical path is one 32-bit adder or shifter plus result selection.
// Reset (synchronous, active low) clears both stage valid bits; payload is not reset.
`timescale 1ns / 1ps

module rv32i_integer_execute
    import rvx_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    // instruction[31:0], pc[63:32], rs1_value[95:64], rs2_value[127:96]
    input  logic [127:0]   i_s_axis_tdata,
    output logic           o_m_axis_tvalid,
    input  logic           i_m_axis_tready,
    // dest_index[4:0], dest_write[5], dest_value[37:6], next_pc[69:38], status[71:70]
    output logic [71:0]    o_m_axis_tdata
);

    logic        r_in_valid;
    logic [31:0] r_in_instruction;
    logic [31:0] r_in_pc;
    logic [31:0] r_in_rs1;
    logic [31:0] r_in_rs2;
    logic        r_out_valid;
    t_exec_res   r_out;
    t_exec_res   w_res;
    logic        w_out_ready;
    logic        w_adv;
    logic        w_take;

    assign w_out_ready     = !r_out_valid || i_m_axis_tready;
    assign w_adv           = r_in_valid && w_out_ready;
    assign o_s_axis_tready = !r_in_valid || w_out_ready;
    assign w_take          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_instruction <= i_s_axis_tdata[31:0];
            r_in_pc          <= i_s_axis_tdata[63:32];
            r_in_rs1         <= i_s_axis_tdata[95:64];
            r_in_rs2         <= i_s_axis_tdata[127:96];
        end
    end

    rvx_exec u_exec (
        .i_instruction (r_in_instruction),
        .i_pc          (r_in_pc),
        .i_rs1_value   (r_in_rs1),
        .i_rs2_value   (r_in_rs2),
        .o_res         (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.status, r_out.next_pc, r_out.dest_value,
                              r_out.dest_write, r_out.dest_index};

    a_write_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.dest_write |-> r_out.status == ST_DONE && r_out.dest_index != 5'd0)
        else $error("dest write with bad status or x0");

    a_fault_clears_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status != ST_DONE |-> r_out.dest_index == 5'd0
            && r_out.dest_value == 32'd0)
        else $error("faulting item carries destination data");

    a_misalign_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_in_pc[1:0] != 2'd0 |=> r_out.status == ST_MISALIGN)
        else $error("misaligned pc not flagged");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid && !r_in_valid)
        else $error("stages not empty after reset");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the RV32I integer execute block: directed rows, then random items.
`timescale 1ns / 1ps

module tb_top;
    import rvx_pkg::*;

    localparam logic [6:0] OPC_FENCE = 7'b0001111;
    localparam logic [6:0] OPC_AMO   = 7'b0101111;
    localparam logic [2:0] F3_BR_RSVD = 3'b010;
    localparam int unsigned RANDOM_ITEMS = 925;
    localparam int unsigned IDLE_LIMIT   = 2000;

    typedef struct packed {
        logic [31:0] instr;
        logic [31:0] pc;
        logic [31:0] rs1;
        logic [31:0] rs2;
        logic        typed;
        t_exec_res   res;
    } t_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_s_axis_tvalid = 1'b0;
    logic          o_s_axis_tready;
    // instruction, pc, rs1_value, rs2_value
    logic [127:0]  i_s_axis_tdata = '0;
    logic          o_m_axis_tvalid;
    logic          i_m_axis_tready = 1'b0;
    // dest_index, dest_write, dest_value, next_pc, status
    logic [71:0]   o_m_axis_tdata;

    logic          row_typed = 1'b0;
    t_exec_res     row_res = '0;
    t_exec_res     exec_results_due[$];
    t_row          directed_rows[$];
    int unsigned   errors = 0;
    int unsigned   idle_cycles = 0;
    logic [9:0]    rx_phase = '0;

    rv32i_integer_execute dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_exec_res predict_exec(input logic [31:0] ir, pc, a, b);
        t_exec_res   r;
        t_status     st;
        logic [4:0]  rd;
        logic [31:0] val, npc, imm_i, opnd;
        logic [4:0]  sh;
        logic        taken;
        rd    = ir[11:7];
        val   = '0;
        npc   = pc + 32'd4;
        st    = ST_DONE;
        taken = 1'b0;
        imm_i = {{20{ir[31]}}, ir[31:20]};
        if (pc[1:0] != 2'b00) begin
            st = ST_MISALIGN;
        end else begin
            case (ir[6:0])
                OPC_LUI: val = {ir[31:12], 12'b0};
                OPC_AUIPC: val = pc + {ir[31:12], 12'b0};
                OPC_JAL: begin
                    val = pc + 32'd4;
                    npc = pc + {{11{ir[31]}}, ir[31], ir[19:12], ir[20], ir[30:21], 1'b0};
                end
                OPC_JALR: begin
                    val = pc + 32'd4;
                    npc = (a + imm_i) & ~32'd1;
                end
                OPC_BRANCH: begin
                    rd = '0;
                    case (ir[14:12])
                        F3_BEQ:  taken = (a == b);
                        F3_BNE:  taken = (a != b);
                        F3_BLT:  taken = ($signed(a) < $signed(b));
                        F3_BGE:  taken = !($signed(a) < $signed(b));
                        F3_BLTU: taken = (a < b);
                        F3_BGEU: taken = (a >= b);
                        default: st = ST_ILLEGAL;
                    endcase
                    if (st == ST_DONE && taken)
                        npc = pc + {{19{ir[31]}}, ir[31], ir[7], ir[30:25], ir[11:8], 1'b0};
                end
                OPC_OPIMM, OPC_OP: begin
                    opnd = ir[5] ? b : imm_i;
                    sh   = opnd[4:0];
                    if (ir[5] && ir[25]) begin
                        st = ST_ILLEGAL;
                    end else begin
                        case (ir[14:12])
                            F3_ADD:  val = (ir[5] && ir[30]) ? a - opnd : a + opnd;
                            F3_SLL:  val = a << sh;
                            F3_SLT:  val = {31'b0, $signed(a) < $signed(opnd)};
                            F3_SLTU: val = {31'b0, a < opnd};
                            F3_XOR:  val = a ^ opnd;
                            F3_SR: begin
                                if (ir[30])
                                    val = $signed(a) >>> sh;
                                else
                                    val = a >> sh;
                            end
                            F3_OR:   val = a | opnd;
                            default: val = a & opnd;
                        endcase
                    end
                end
                OPC_LOAD, OPC_STORE, OPC_SYSTEM: st = ST_ELSEWHERE;
                default: st = ST_ILLEGAL;
            endcase
        end
        if (st != ST_DONE) begin
            rd  = '0;
            val = '0;
            npc = pc;
        end
        r.status     = st;
        r.next_pc    = npc;
        r.dest_value = val;
        r.dest_write = (st == ST_DONE) && (rd != 5'd0);
        r.dest_index = rd;
        return r;
    endfunction

    function automatic logic [31:0] enc_u(input logic [19:0] imm, input logic [4:0] rd,
                                          input logic [6:0] opc);
        return {imm, rd, opc};
    endfunction

    function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [2:0] f3,
                                          input logic [4:0] rd, input logic [6:0] opc);
        return {imm, 5'd1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [2:0] f3,
                                          input logic [4:0] rd);
        return {f7, 5'd2, 5'd1, f3, rd, OPC_OP};
    endfunction

    function automatic logic [31:0] enc_b(input logic [12:0] off, input logic [2:0] f3);
        return {off[12], off[10:5], 5'd2, 5'd1, f3, off[4:1], off[11], OPC_BRANCH};
    endfunction

    function automatic logic [31:0] enc_j(input logic [20:0] off, input logic [4:0] rd);
        return {off[20], off[10:1], off[11], off[19:12], rd, OPC_JAL};
    endfunction

    function automatic void add_row(input logic [31:0] instr, pc, rs1, rs2,
                                    input logic typed = 1'b0, input t_exec_res res = '0);
        t_row row;
        row.instr = instr;
        row.pc    = pc;
        row.rs1   = rs1;
        row.rs2   = rs2;
        row.typed = typed;
        row.res   = res;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 63);
            default: return $urandom;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want, got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // receiver stall pattern: open, periodic, sparse and random phases
    always @(negedge i_clk) begin
        rx_phase <= rx_phase + 10'd1;
        case (rx_phase[9:7])
            3'd0, 3'd1: i_m_axis_tready <= 1'b1;
            3'd2:       i_m_axis_tready <= (rx_phase[1:0] != 2'd3);
            3'd3:       i_m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:    i_m_axis_tready <= ($urandom_range(0, 1) == 1);
        endcase
    end

    always @(posedge i_clk) begin
        t_exec_res got, want;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = o_m_axis_tdata;
                if (exec_results_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: expected none, actual %h",
                             $time, o_m_axis_tdata);
                end else begin
                    want = exec_results_due.pop_front();
                    check_field("dest_index", want.dest_index, got.dest_index);
                    check_field("dest_write", want.dest_write, got.dest_write);
                    check_field("dest_value", want.dest_value, got.dest_value);
                    check_field("next_pc", want.next_pc, got.next_pc);
                    check_field("status", want.status, got.status);
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                if (row_typed)
                    exec_results_due.push_back(row_res);
                else
                    exec_results_due.push_back(predict_exec(i_s_axis_tdata[31:0],
                        i_s_axis_tdata[63:32], i_s_axis_tdata[95:64], i_s_axis_tdata[127:96]));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] instr, pc, rs1, rs2;
        t_row        row;
        int          burst_left, gap, total;

        add_row(enc_u(20'hFFFFF, 5'd31, OPC_LUI), 32'h0, 32'h0, 32'h0, 1'b1,
                t_exec_res'({ST_DONE, 32'd4, 32'hFFFF_F000, 1'b1, 5'd31}));
        add_row(enc_u(20'h80000, 5'd1, OPC_AUIPC), 32'hFFFF_FFFC, 32'h0, 32'h0);
        add_row(enc_j(21'h100000, 5'd5), 32'h0000_1000, 32'h0, 32'h0);
        add_row(enc_i(12'h7FF, F3_SLTU, 5'd2, OPC_JALR), 32'h100, 32'hFFFF_FFFF, 32'h0);
        add_row(enc_b(13'h1000, F3_BEQ), 32'h2000, 32'h1234_5678, 32'h1234_5678);
        add_row(enc_b(13'h0FFE, F3_BNE), 32'h2000, 32'h0, 32'h1);
        add_row(enc_b(13'h1FFC, F3_BLT), 32'h2000, 32'h8000_0000, 32'h7FFF_FFFF);
        add_row(enc_b(13'h0010, F3_BGE), 32'h2000, 32'h8000_0000, 32'h7FFF_FFFF);
        add_row(enc_b(13'h0008, F3_BLTU), 32'h2000, 32'h7FFF_FFFF, 32'h8000_0000);
        add_row(enc_b(13'h0008, F3_BGEU), 32'h2000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_row(enc_b(13'h0008, F3_BR_RSVD), 32'h40, 32'h0, 32'h0, 1'b1,
                t_exec_res'({ST_ILLEGAL, 32'h40, 32'd0, 1'b0, 5'd0}));
        add_row(enc_r(7'h00, F3_ADD, 5'd3), 32'h4, 32'hFFFF_FFFF, 32'h1);
        add_row(enc_r(7'h20, F3_ADD, 5'd3), 32'h8, 32'h0, 32'h1);
        add_row(enc_i({7'b1010101, 5'd31}, F3_SLL, 5'd4, OPC_OPIMM), 32'hC, 32'h1, 32'h0);
        add_row(enc_r(7'h00, F3_SLT, 5'd6), 32'h10, 32'h8000_0000, 32'h1);
        add_row(enc_i(12'hFFF, F3_SLTU, 5'd7, OPC_OPIMM), 32'h14, 32'hFFFF_FFFE, 32'h0);
        add_row(enc_r(7'h00, F3_XOR, 5'd8), 32'h18, 32'hA5A5_A5A5, 32'hFFFF_0000);
        add_row(enc_r(7'h00, F3_SR, 5'd9), 32'h1C, 32'h8000_0000, 32'hFFFF_FFE1);
        add_row(enc_i({7'b0100000, 5'd31}, F3_SR, 5'd10, OPC_OPIMM), 32'h20,
                32'h8000_0000, 32'h0);
        add_row(enc_r(7'h20, F3_SR, 5'd11), 32'h24, 32'h8000_0001, 32'h0000_003F);
        add_row(enc_r(7'h00, F3_OR, 5'd12), 32'h28, 32'h0F0F_0000, 32'h0000_F0F0);
        add_row(enc_i(12'h800, F3_AND, 5'd13, OPC_OPIMM), 32'h2C, 32'hFFFF_FFFF, 32'h0);
        add_row(enc_r(7'h01, F3_ADD, 5'd14), 32'h80, 32'h5, 32'h6, 1'b1,
                t_exec_res'({ST_ILLEGAL, 32'h80, 32'd0, 1'b0, 5'd0}));
        add_row(enc_i(12'h004, 3'b010, 5'd15, OPC_LOAD), 32'h84, 32'h100, 32'h0, 1'b1,
                t_exec_res'({ST_ELSEWHERE, 32'h84, 32'd0, 1'b0, 5'd0}));
        add_row(enc_i(12'h0FF, 3'b000, 5'd0, OPC_FENCE), 32'h88, 32'h0, 32'h0, 1'b1,
                t_exec_res'({ST_ILLEGAL, 32'h88, 32'd0, 1'b0, 5'd0}));
        add_row(enc_u(20'h12345, 5'd1, OPC_LUI), 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1,
                t_exec_res'({ST_MISALIGN, 32'hFFFF_FFFF, 32'd0, 1'b0, 5'd0}));

        total = directed_rows.size() + RANDOM_ITEMS;
        burst_left = $urandom_range(1, 24);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < total; i++) begin
            if (i < directed_rows.size()) begin
                row = directed_rows[i];
            end else begin
                instr = $urandom;
                rs1 = pick_operand();
                rs2 = pick_operand();
                pc = ($urandom_range(0, 19) == 0) ? $urandom : ($urandom & 32'hFFFF_FFFC);
                case ($urandom_range(0, 15))
                    0:  instr[6:0] = OPC_LUI;
                    1:  instr[6:0] = OPC_AUIPC;
                    2:  instr[6:0] = OPC_JAL;
                    3:  instr[6:0] = OPC_JALR;
                    4, 5: begin
                        instr[6:0] = OPC_BRANCH;
                        if ($urandom_range(0, 2) == 0)
                            rs2 = rs1;
                    end
                    6, 7, 8: instr[6:0] = OPC_OPIMM;
                    9, 10, 11: begin
                        instr[6:0] = OPC_OP;
                        if ($urandom_range(0, 7) != 0)
                            instr[31:25] = {1'b0, instr[30], 5'b0};
                    end
                    12: begin
                        case ($urandom_range(0, 2))
                            0:       instr[6:0] = OPC_LOAD;
                            1:       instr[6:0] = OPC_STORE;
                            default: instr[6:0] = OPC_SYSTEM;
                        endcase
                    end
                    13: instr[6:0] = $urandom_range(0, 1) ? OPC_FENCE : OPC_AMO;
                    default: ;  // raw noise word
                endcase
                row = '0;
                row.instr = instr;
                row.pc    = pc;
                row.rs1   = rs1;
                row.rs2   = rs2;
            end

            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tdata  <= {row.rs2, row.rs1, row.pc, row.instr};
            row_typed       <= row.typed;
            row_res         <= row.res;
            do @(posedge i_clk); while (!o_s_axis_tready);

            burst_left--;
            if (burst_left <= 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    @(negedge i_clk);
                    i_s_axis_tvalid <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
                burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
            end
        end

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (exec_results_due.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
